// ===== rtl/segment_segment_intersection_macros.svh =====
// Assertion macros shared by the segment intersection design.
`ifndef SEGMENT_SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_SEGMENT_INTERSECTION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

// Next-cycle implication, checked outside reset.
`define SSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

`endif

// ===== rtl/ssi_pkg.sv =====
// Package with widths and types of the segment intersection pipeline.
`timescale 1ns / 1ps
package ssi_pkg;
  localparam int CW = 32;        // coordinate width
  localparam int DW = CW + 1;    // coordinate difference width
  localparam int PW = 2 * DW;    // cross product width
  localparam int NW = PW + 2;    // signed numerator and denominator width
  localparam int MW = NW - 1;    // numerator and denominator magnitude width
  localparam int QW = DW;        // quotient width
  localparam int RW = QW + MW;   // scaled numerator width
  localparam int LW = 34;        // low slice of the numerator in the split multiply
  localparam int HW = MW - LW;   // high slice

  typedef struct packed {
    logic          hit;
    logic [MW-1:0] na;
    logic [MW-1:0] den;
    logic [QW-1:0] mag_x;
    logic [QW-1:0] mag_y;
    logic          neg_x;
    logic          neg_y;
    logic [CW-1:0] start_x;
    logic [CW-1:0] start_y;
  } ssi_front_t;

  typedef struct packed {
    logic          hit;
    logic          neg;
    logic [CW-1:0] start;
  } ssi_tag_t;
endpackage

// ===== rtl/ssi_cross.sv =====
// Front end: differences, cross products, sign normalization and range test.
`timescale 1ns / 1ps
module ssi_cross import ssi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] asx,
  input  logic signed [CW-1:0] asy,
  input  logic signed [CW-1:0] aex,
  input  logic signed [CW-1:0] aey,
  input  logic signed [CW-1:0] bsx,
  input  logic signed [CW-1:0] bsy,
  input  logic signed [CW-1:0] bex,
  input  logic signed [CW-1:0] bey,
  output logic                 valid_o,
  output ssi_front_t           fr_o
);
  logic [3:0] vld_r;

  // Stage one: differences.
  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r, ox_r, oy_r;
  logic signed [CW-1:0] s1x_r, s1y_r;
  // Stage two: products.
  logic signed [PW-1:0] p_bo_r, p_bx_r, p_ao_r, p_ax_r, p_d1_r, p_d2_r;
  logic signed [DW-1:0] dax2_r, day2_r;
  logic signed [CW-1:0] s2x_r, s2y_r;
  // Stage three: numerators and denominator.
  logic signed [NW-1:0] na_r, nb_r, d_r;
  logic signed [DW-1:0] dax3_r, day3_r;
  logic signed [CW-1:0] s3x_r, s3y_r;
  // Stage four: normalized outputs.
  ssi_front_t fr_r, fr_nxt;

  logic signed [NW-1:0] dn, nan, nbn, ra, rb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    dax_r  <= DW'(aex) - DW'(asx);
    day_r  <= DW'(aey) - DW'(asy);
    dbx_r  <= DW'(bex) - DW'(bsx);
    dby_r  <= DW'(bey) - DW'(bsy);
    ox_r   <= DW'(asx) - DW'(bsx);
    oy_r   <= DW'(asy) - DW'(bsy);
    s1x_r  <= asx;
    s1y_r  <= asy;

    p_bo_r <= dbx_r * oy_r;
    p_bx_r <= dby_r * ox_r;
    p_ao_r <= dax_r * oy_r;
    p_ax_r <= day_r * ox_r;
    p_d1_r <= dby_r * dax_r;
    p_d2_r <= dbx_r * day_r;
    dax2_r <= dax_r;
    day2_r <= day_r;
    s2x_r  <= s1x_r;
    s2y_r  <= s1y_r;

    na_r   <= NW'(p_bo_r) - NW'(p_bx_r);
    nb_r   <= NW'(p_ao_r) - NW'(p_ax_r);
    d_r    <= NW'(p_d1_r) - NW'(p_d2_r);
    dax3_r <= dax2_r;
    day3_r <= day2_r;
    s3x_r  <= s2x_r;
    s3y_r  <= s2y_r;

    fr_r   <= fr_nxt;
  end

  // Flip signs so the denominator is positive, then test both positions.
  always_comb begin
    dn  = d_r[NW-1] ? -d_r  : d_r;
    nan = d_r[NW-1] ? -na_r : na_r;
    nbn = d_r[NW-1] ? -nb_r : nb_r;
    ra  = dn - nan;
    rb  = dn - nbn;
    fr_nxt.hit     = (d_r != '0) && !nan[NW-1] && !ra[NW-1] && !nbn[NW-1] && !rb[NW-1];
    fr_nxt.na      = nan[MW-1:0];
    fr_nxt.den     = dn[MW-1:0];
    fr_nxt.neg_x   = dax3_r[DW-1];
    fr_nxt.neg_y   = day3_r[DW-1];
    fr_nxt.mag_x   = dax3_r[DW-1] ? QW'(-dax3_r) : QW'(dax3_r);
    fr_nxt.mag_y   = day3_r[DW-1] ? QW'(-day3_r) : QW'(day3_r);
    fr_nxt.start_x = s3x_r;
    fr_nxt.start_y = s3y_r;
  end

  assign valid_o = vld_r[3];
  assign fr_o    = fr_r;
endmodule

// ===== rtl/ssi_div_cell.sv =====
// One restoring division cell: decides one quotient bit and passes the rest on.
`timescale 1ns / 1ps
module ssi_div_cell import ssi_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  ssi_tag_t      tag_i,
  input  logic [RW-1:0] rem_i,
  input  logic [MW-1:0] den_i,
  input  logic [QW-1:0] q_i,
  output logic          valid_o,
  output ssi_tag_t      tag_o,
  output logic [RW-1:0] rem_o,
  output logic [MW-1:0] den_o,
  output logic [QW-1:0] q_o
);
  logic          valid_r;
  ssi_tag_t      tag_r;
  logic [RW-1:0] rem_r, rem_nxt, trial;
  logic [MW-1:0] den_r;
  logic [QW-1:0] q_r, q_nxt;

  always_comb begin
    trial = RW'(den_i) << BIT;
    if (rem_i >= trial) begin
      rem_nxt = rem_i - trial;
      q_nxt   = q_i | (QW'(1) << BIT);
    end else begin
      rem_nxt = rem_i;
      q_nxt   = q_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_i;
    rem_r <= rem_nxt;
    den_r <= den_i;
    q_r   <= q_nxt;
  end

  assign valid_o = valid_r;
  assign tag_o   = tag_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign q_o     = q_r;
endmodule

// ===== rtl/segment_segment_intersection.sv =====
// Top level of the two-dimensional segment intersection pipeline.
// Throughput: one item per cycle; busy is always low and start may be held every cycle.
// The rate is set by the fully pipelined front end and the 33-cell division chains.
// Reset (rst_n low, synchronous) clears every valid bit; items in flight are dropped.
// The receiver cannot stall, so each result appears for exactly one cycle.
`timescale 1ns / 1ps
module segment_segment_intersection import ssi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_a_start_x,
  input  logic signed [CW-1:0] in_a_start_y,
  input  logic signed [CW-1:0] in_a_end_x,
  input  logic signed [CW-1:0] in_a_end_y,
  input  logic signed [CW-1:0] in_b_start_x,
  input  logic signed [CW-1:0] in_b_start_y,
  input  logic signed [CW-1:0] in_b_end_x,
  input  logic signed [CW-1:0] in_b_end_y,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic signed [CW-1:0] out_hit_x,
  output logic signed [CW-1:0] out_hit_y
);
`include "segment_segment_intersection_macros.svh"

  // The pipeline never stalls, so the block is never busy.
  assign busy = 1'b0;

  logic       fr_valid;
  ssi_front_t fr;

  // The front end forms the cross-product numerators over the shared denominator,
  // normalizes the denominator to be positive and decides whether the segments hit.
  ssi_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .asx     (in_a_start_x),
    .asy     (in_a_start_y),
    .aex     (in_a_end_x),
    .aey     (in_a_end_y),
    .bsx     (in_b_start_x),
    .bsy     (in_b_start_y),
    .bex     (in_b_end_x),
    .bey     (in_b_end_y),
    .valid_o (fr_valid),
    .fr_o    (fr)
  );

  // The scaled numerator |dA| * na is wider than one multiplier, so it is split into
  // two partial products over the low and high slices of na and summed one stage later.
  logic          pp_valid_r, sum_valid_r;
  logic [QW+LW-1:0] plo_x_r, plo_y_r;
  logic [QW+HW-1:0] phi_x_r, phi_y_r;
  logic [MW-1:0] den5_r, den6_r;
  ssi_tag_t      tag5_x_r, tag5_y_r, tag6_x_r, tag6_y_r;
  logic [RW-1:0] sum_x_r, sum_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_valid_r  <= 1'b0;
      sum_valid_r <= 1'b0;
    end else begin
      pp_valid_r  <= fr_valid;
      sum_valid_r <= pp_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    plo_x_r  <= (QW+LW)'(fr.mag_x) * (QW+LW)'(fr.na[LW-1:0]);
    plo_y_r  <= (QW+LW)'(fr.mag_y) * (QW+LW)'(fr.na[LW-1:0]);
    phi_x_r  <= (QW+HW)'(fr.mag_x) * (QW+HW)'(fr.na[MW-1:LW]);
    phi_y_r  <= (QW+HW)'(fr.mag_y) * (QW+HW)'(fr.na[MW-1:LW]);
    den5_r   <= fr.den;
    tag5_x_r <= '{hit: fr.hit, neg: fr.neg_x, start: fr.start_x};
    tag5_y_r <= '{hit: fr.hit, neg: fr.neg_y, start: fr.start_y};

    sum_x_r  <= RW'(plo_x_r) + (RW'(phi_x_r) << LW);
    sum_y_r  <= RW'(plo_y_r) + (RW'(phi_y_r) << LW);
    den6_r   <= den5_r;
    tag6_x_r <= tag5_x_r;
    tag6_y_r <= tag5_y_r;
  end

  // Two chains of restoring division cells, one per coordinate. Each cell settles
  // one quotient bit, most significant first; for a hit the quotient never exceeds |dA|.
  logic          cv_x [QW+1];
  logic          cv_y [QW+1];
  ssi_tag_t      ct_x [QW+1];
  ssi_tag_t      ct_y [QW+1];
  logic [RW-1:0] cr_x [QW+1];
  logic [RW-1:0] cr_y [QW+1];
  logic [MW-1:0] cd_x [QW+1];
  logic [MW-1:0] cd_y [QW+1];
  logic [QW-1:0] cq_x [QW+1];
  logic [QW-1:0] cq_y [QW+1];

  assign cv_x[0] = sum_valid_r;
  assign cv_y[0] = sum_valid_r;
  assign ct_x[0] = tag6_x_r;
  assign ct_y[0] = tag6_y_r;
  assign cr_x[0] = sum_x_r;
  assign cr_y[0] = sum_y_r;
  assign cd_x[0] = den6_r;
  assign cd_y[0] = den6_r;
  assign cq_x[0] = '0;
  assign cq_y[0] = '0;

  for (genvar gk = 0; gk < QW; gk++) begin : g_div
    ssi_div_cell #(.BIT(QW - 1 - gk)) u_cell_x (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (cv_x[gk]),
      .tag_i   (ct_x[gk]),
      .rem_i   (cr_x[gk]),
      .den_i   (cd_x[gk]),
      .q_i     (cq_x[gk]),
      .valid_o (cv_x[gk+1]),
      .tag_o   (ct_x[gk+1]),
      .rem_o   (cr_x[gk+1]),
      .den_o   (cd_x[gk+1]),
      .q_o     (cq_x[gk+1])
    );
    ssi_div_cell #(.BIT(QW - 1 - gk)) u_cell_y (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (cv_y[gk]),
      .tag_i   (ct_y[gk]),
      .rem_i   (cr_y[gk]),
      .den_i   (cd_y[gk]),
      .q_i     (cq_y[gk]),
      .valid_o (cv_y[gk+1]),
      .tag_o   (ct_y[gk+1]),
      .rem_o   (cr_y[gk+1]),
      .den_o   (cd_y[gk+1]),
      .q_o     (cq_y[gk+1])
    );
  end

  // The truncated offset is added to or taken from A's start according to the sign
  // of A's direction. A miss reports zero coordinates.
  logic          out_valid_r, out_hit_r;
  logic [CW-1:0] out_x_r, out_y_r, x_nxt, y_nxt;
  logic [DW-1:0] ax_full, ay_full;

  always_comb begin
    ax_full = ct_x[QW].neg ? DW'(ct_x[QW].start) - cq_x[QW] : DW'(ct_x[QW].start) + cq_x[QW];
    ay_full = ct_y[QW].neg ? DW'(ct_y[QW].start) - cq_y[QW] : DW'(ct_y[QW].start) + cq_y[QW];
    x_nxt   = ct_x[QW].hit ? ax_full[CW-1:0] : '0;
    y_nxt   = ct_x[QW].hit ? ay_full[CW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      out_valid_r <= cv_x[QW];
      out_hit_r   <= cv_x[QW] && ct_x[QW].hit;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r <= x_nxt;
    out_y_r <= y_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_hit_x = out_x_r;
  assign out_hit_y = out_y_r;

  // A miss must carry zero coordinates, a hit flag never appears without the strobe,
  // the end of the division chain always yields a strobe, and the valid bits of the two chains agree.
  `SSI_ASSERT_IMPL(a_miss_zero, out_valid && !out_hit, out_hit_x == '0 && out_hit_y == '0)
  `SSI_ASSERT_IMPL(a_hit_strobed, out_hit, out_valid)
  `SSI_ASSERT_NEXT(a_chain_to_out, cv_x[QW], out_valid)
  `SSI_ASSERT_IMPL(a_chains_aligned, cv_x[QW] || cv_y[QW], cv_x[QW] && cv_y[QW])
endmodule
